[src/pcrb_pkg.sv]
// shared types and constants for the packet cell ring buffer
package pcrb_pkg;

  // field widths of the stream words
  localparam int OP_W   = 2;
  localparam int WORD_W = 64;
  localparam int STAT_W = 3;
  localparam int CIDX_W = 4;
  localparam int CNT_W  = 4;
  localparam int LOST_W = 32;
  localparam int OCC_W  = 5;

  localparam int OUT_FIELDS_W = WORD_W + CIDX_W + CNT_W + LOST_W + OCC_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_PULL    = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  // result codes
  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_PULL_DATA = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_REL_ERR   = 3'd6
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOOK,
    S_TEST,
    S_PREAD,
    S_PEMIT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic in_load;
    logic clr_step;
    logic exec;
    logic scan_start;
    logic len_rd;
    logic scan_hit;
    logic scan_next;
    logic word_rd;
    logic word_emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            busy;
    logic            full;
    logic            empty;
    logic            out_free;
    logic            clr_done;
    logic            scan_hit;
    logic            pull_last;
  } sts_t;

endpackage

[src/packet_cell_ring_buffer.sv]
// ring of fixed packet cells: push, pull and release over word streams
// an accepted word and its result are registered; the first word of a packet while
// the ring is not full, and a pull while it is not empty, first scan the length table
// from the ring index; a pull then reads and emits its cell's words in turn, each one
// waiting while the output is stalled; one request in flight: no new word is taken
// until the last one's result is issued; reset: the length table is cleared, no word taken
module packet_cell_ring_buffer
  import pcrb_pkg::*;
#(
  parameter int NUM_CELLS  = 16,
  parameter int CELL_WORDS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [WORD_W-1:0]     s_axis_tdata,  // data_word
  input  logic [OP_W-1:0]       s_axis_tuser,  // opcode
  input  logic                  s_axis_tlast,  // last_word
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // read_word, cell_index, word_count,
                                               // lost_count, occupancy, zero pad
  output logic [STAT_W-1:0]     m_axis_tuser,  // status
  output logic                  m_axis_tlast   // last_of_run
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  pcrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  pcrb_dp #(
    .NUM_CELLS  (NUM_CELLS),
    .CELL_WORDS (CELL_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .s_last_i   (s_axis_tlast),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

[src/pcrb_dp.sv]
// datapath: cell tables, ring indices, counters and output register
module pcrb_dp
  import pcrb_pkg::*;
#(
  parameter int NUM_CELLS  = 16,
  parameter int CELL_WORDS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [WORD_W-1:0]     s_data_i,   // data_word
  input  logic [OP_W-1:0]       s_user_i,   // opcode
  input  logic                  s_last_i,   // last_word
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_tdata_o,  // read_word, cell_index, word_count,
                                            // lost_count, occupancy, zero pad
  output logic [STAT_W-1:0]     m_tuser_o,  // status
  output logic                  m_tlast_o   // last_of_run
);

  localparam int CI_W  = $clog2(NUM_CELLS);
  localparam int LEN_W = $clog2(CELL_WORDS + 1);
  localparam int FC_W  = $clog2(NUM_CELLS + 1);
  localparam int DEPTH = NUM_CELLS * CELL_WORDS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [CI_W-1:0]   LAST_CELL = CI_W'(NUM_CELLS - 1);
  localparam logic [LEN_W-1:0]  CW_LEN    = LEN_W'(CELL_WORDS);
  localparam logic [FC_W-1:0]   NC_CNT    = FC_W'(NUM_CELLS);
  localparam logic [LOST_W-1:0] LOST_MAX  = '1;

  function automatic logic [CI_W-1:0] next_cell(input logic [CI_W-1:0] c);
    next_cell = (c == LAST_CELL) ? '0 : c + 1'b1;
  endfunction

  // input word register
  logic [OP_W-1:0]   in_op_q;
  logic [WORD_W-1:0] in_word_q;
  logic              in_last_q;

  // ring state
  logic [CI_W-1:0]   prod_q, prod_d, cons_q, cons_d;
  logic [CI_W-1:0]   push_cell_q, push_cell_d, ptr_q, ptr_d;
  logic [FC_W-1:0]   full_q, full_d;
  logic [LOST_W-1:0] lost_q, lost_d;
  logic              busy_q, busy_d, drop_q, drop_d, held_q, held_d;
  logic [LEN_W-1:0]  wr_off_q, wr_off_d, rd_cnt_q, rd_cnt_d;
  logic [LEN_W-1:0]  pull_len_q, pull_len_d;

  // memories
  logic [LEN_W-1:0]  len_mem [NUM_CELLS];
  logic [WORD_W-1:0] store_mem [DEPTH];
  logic [LEN_W-1:0]  len_rd_q;
  logic [WORD_W-1:0] word_rd_q;
  logic              len_we, store_we;
  logic [CI_W-1:0]   len_waddr;
  logic [LEN_W-1:0]  len_wdata;
  logic [AW-1:0]     store_waddr, store_raddr;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  logic [CIDX_W-1:0] out_cell_q, out_cell_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic              out_last_q, out_last_d;
  logic [LOST_W-1:0] out_lost_q, out_lost_d;
  logic [OCC_W-1:0]  out_occ_q, out_occ_d;

  // result being formed this cycle
  logic              emit;
  status_e           e_status;
  logic [WORD_W-1:0] e_word;
  logic [CI_W-1:0]   e_cell;
  logic [LEN_W-1:0]  e_count;
  logic              e_last;
  logic [LEN_W-1:0]  wr_new;
  logic              pull_last;

  assign store_waddr = AW'(32'(push_cell_q) * 32'(CELL_WORDS) + 32'(wr_off_q));
  assign store_raddr = AW'(32'(cons_q) * 32'(CELL_WORDS) + 32'(rd_cnt_q));
  assign pull_last   = (rd_cnt_q + 1'b1) == pull_len_q;

  // status towards the controller
  always_comb begin
    sts_o.op        = in_op_q;
    sts_o.busy      = busy_q;
    sts_o.full      = full_q == NC_CNT;
    sts_o.empty     = full_q == '0;
    sts_o.out_free  = !out_valid_q || m_tready_i;
    sts_o.clr_done  = ptr_q == LAST_CELL;
    sts_o.scan_hit  = (in_op_q == OP_PUSH) ? (len_rd_q == '0) : (len_rd_q != '0);
    sts_o.pull_last = pull_last;
  end

  // next state of the ring and the result to emit
  always_comb begin
    prod_d      = prod_q;
    cons_d      = cons_q;
    push_cell_d = push_cell_q;
    ptr_d       = ptr_q;
    full_d      = full_q;
    lost_d      = lost_q;
    busy_d      = busy_q;
    drop_d      = drop_q;
    held_d      = held_q;
    wr_off_d    = wr_off_q;
    rd_cnt_d    = rd_cnt_q;
    pull_len_d  = pull_len_q;
    len_we      = 1'b0;
    len_waddr   = ptr_q;
    len_wdata   = '0;
    store_we    = 1'b0;
    emit        = 1'b0;
    e_status    = ST_PUSHED;
    e_word      = '0;
    e_cell      = '0;
    e_count     = '0;
    e_last      = 1'b1;
    wr_new      = wr_off_q;

    // clearing pass over the length table
    if (cmd_i.clr_step) begin
      len_we = 1'b1;
      ptr_d  = ptr_q + 1'b1;
    end

    if (cmd_i.scan_start) begin
      ptr_d = (in_op_q == OP_PUSH) ? prod_q : cons_q;
    end

    if (cmd_i.scan_next) begin
      ptr_d = next_cell(ptr_q);
    end

    // free cell found for a push, or full cell found for a pull
    if (cmd_i.scan_hit) begin
      if (in_op_q == OP_PUSH) begin
        prod_d      = ptr_q;
        push_cell_d = ptr_q;
        busy_d      = 1'b1;
        drop_d      = 1'b0;
        wr_off_d    = '0;
      end else begin
        cons_d     = ptr_q;
        held_d     = 1'b1;
        pull_len_d = len_rd_q;
        rd_cnt_d   = '0;
      end
    end

    // single-result requests
    if (cmd_i.exec) begin
      case (in_op_q)
        OP_PUSH: begin
          emit = 1'b1;
          if (!busy_q || drop_q) begin
            if (!busy_q && lost_q != LOST_MAX) begin
              lost_d = lost_q + 1'b1;
            end
            busy_d   = !in_last_q;
            drop_d   = !in_last_q;
            e_status = ST_DROPPED;
          end else begin
            if (wr_off_q < CW_LEN) begin
              store_we = 1'b1;
              wr_new   = wr_off_q + 1'b1;
              e_status = ST_PUSHED;
            end else begin
              e_status = ST_TRUNC;
            end
            wr_off_d = wr_new;
            if (in_last_q) begin
              len_we    = 1'b1;
              len_waddr = push_cell_q;
              len_wdata = wr_new;
              full_d    = full_q + 1'b1;
              prod_d    = next_cell(push_cell_q);
              busy_d    = 1'b0;
              wr_off_d  = '0;
            end
            e_cell  = push_cell_q;
            e_count = wr_new;
          end
        end
        OP_PULL: begin
          emit     = 1'b1;
          e_status = ST_EMPTY;
        end
        OP_RELEASE: begin
          emit = 1'b1;
          if (!held_q) begin
            e_status = ST_REL_ERR;
          end else begin
            len_we    = 1'b1;
            len_waddr = cons_q;
            held_d    = 1'b0;
            cons_d    = next_cell(cons_q);
            if (full_q != '0) begin
              full_d = full_q - 1'b1;
            end
            e_status = ST_RELEASED;
            e_cell   = cons_q;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // one word of a pulled packet
    if (cmd_i.word_emit) begin
      emit     = 1'b1;
      e_status = ST_PULL_DATA;
      e_word   = word_rd_q;
      e_cell   = cons_q;
      e_count  = pull_len_q;
      e_last   = pull_last;
      rd_cnt_d = rd_cnt_q + 1'b1;
    end

    out_valid_d  = emit ? 1'b1 : (m_tready_i ? 1'b0 : out_valid_q);
    out_status_d = e_status;
    out_word_d   = e_word;
    out_cell_d   = CIDX_W'(e_cell);
    out_count_d  = CNT_W'(e_count);
    out_last_d   = e_last;
    out_lost_d   = lost_d;
    out_occ_d    = OCC_W'(full_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q      <= '0;
      cons_q      <= '0;
      push_cell_q <= '0;
      ptr_q       <= '0;
      full_q      <= '0;
      lost_q      <= '0;
      busy_q      <= 1'b0;
      drop_q      <= 1'b0;
      held_q      <= 1'b0;
      wr_off_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q      <= prod_d;
      cons_q      <= cons_d;
      push_cell_q <= push_cell_d;
      ptr_q       <= ptr_d;
      full_q      <= full_d;
      lost_q      <= lost_d;
      busy_q      <= busy_d;
      drop_q      <= drop_d;
      held_q      <= held_d;
      wr_off_q    <= wr_off_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_op_q   <= s_user_i;
      in_word_q <= s_data_i;
      in_last_q <= s_last_i;
    end
    rd_cnt_q   <= rd_cnt_d;
    pull_len_q <= pull_len_d;
    if (emit) begin
      out_status_q <= out_status_d;
      out_word_q   <= out_word_d;
      out_cell_q   <= out_cell_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
      out_lost_q   <= out_lost_d;
      out_occ_q    <= out_occ_d;
    end
  end

  // length table
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (cmd_i.len_rd) begin
      len_rd_q <= len_mem[ptr_q];
    end
  end

  // cell word store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_waddr] <= in_word_q;
    end
    if (cmd_i.word_rd) begin
      word_rd_q <= store_mem[store_raddr];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {{OUT_PAD_W{1'b0}}, out_occ_q, out_lost_q, out_count_q,
                       out_cell_q, out_word_q};

endmodule

[src/pcrb_ctrl.sv]
// controller: sequences clearing, scans, requests and pulled words
module pcrb_ctrl
  import pcrb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   need_scan, known_op;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign need_scan = (sts_i.op == OP_PUSH && !sts_i.busy && !sts_i.full) ||
                     (sts_i.op == OP_PULL && !sts_i.empty);
  assign known_op  = sts_i.op == OP_PUSH || sts_i.op == OP_PULL ||
                     sts_i.op == OP_RELEASE;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (need_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_LOOK;
        end else if (!known_op) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_LOOK: begin
        cmd_o.len_rd = 1'b1;
        state_d      = S_TEST;
      end
      S_TEST: begin
        if (sts_i.scan_hit) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = (sts_i.op == OP_PUSH) ? S_EXEC : S_PREAD;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_LOOK;
        end
      end
      S_PREAD: begin
        cmd_o.word_rd = 1'b1;
        state_d       = S_PEMIT;
      end
      S_PEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.word_emit = 1'b1;
          state_d         = sts_i.pull_last ? S_IDLE : S_PREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[test/pcrb_checker.sv]
`timescale 1ns / 100ps
// checker for the packet cell ring buffer: predicts every result word and compares it
module pcrb_checker
  import pcrb_pkg::*;
#(
  parameter int NUM_CELLS  = 16,
  parameter int CELL_WORDS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [WORD_W-1:0]     s_axis_tdata,  // data_word
  input  logic [OP_W-1:0]       s_axis_tuser,  // opcode
  input  logic                  s_axis_tlast,  // last_word
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // read_word, cell_index, word_count,
                                               // lost_count, occupancy, zero pad
  input  logic [STAT_W-1:0]     m_axis_tuser,  // status
  input  logic                  m_axis_tlast,  // last_of_run
  output int                    mismatch_count_o,
  output int                    owed_count_o
);

  // bit offsets of the result fields in tdata
  localparam int CELL_LSB = WORD_W;
  localparam int CNT_LSB  = CELL_LSB + CIDX_W;
  localparam int LOST_LSB = CNT_LSB + CNT_W;
  localparam int OCC_LSB  = LOST_LSB + LOST_W;

  typedef struct packed {
    status_e           status;
    logic [WORD_W-1:0] word;
    logic [CIDX_W-1:0] cell_idx;
    logic [CNT_W-1:0]  count;
    logic              last;
    logic [LOST_W-1:0] lost;
    logic [OCC_W-1:0]  occ;
  } ring_result_t;

  // results still owed by the block, oldest first
  ring_result_t owed_results[$];

  // predicted ring state
  logic [CIDX_W-1:0] prod_idx;
  logic [CIDX_W-1:0] cons_idx;
  logic [CIDX_W-1:0] fill_cell;
  logic [OCC_W-1:0]  ring_occ;
  logic [LOST_W-1:0] lost_pkts;
  logic [CNT_W-1:0]  cell_len [NUM_CELLS];
  logic [WORD_W-1:0] cell_mem [NUM_CELLS*CELL_WORDS];
  logic              filling;
  logic              discarding;
  logic              holding;
  logic [CNT_W-1:0]  fill_off;

  int mismatches;
  int results_seen;

  function automatic logic [CIDX_W-1:0] ring_next(logic [CIDX_W-1:0] c);
    return (int'(c) + 1 >= NUM_CELLS) ? '0 : c + 1'b1;
  endfunction

  // queue one owed result, stamped with the counters after this step
  task automatic owe(status_e st, logic [WORD_W-1:0] w, logic [CIDX_W-1:0] c,
                     logic [CNT_W-1:0] n, logic lst);
    ring_result_t r;
    r.status   = st;
    r.word     = w;
    r.cell_idx = c;
    r.count    = n;
    r.last     = lst;
    r.lost     = lost_pkts;
    r.occ      = ring_occ;
    owed_results.push_back(r);
  endtask

  // advance the ring state by one accepted word and queue what it causes
  task automatic predict_ring_step(logic [OP_W-1:0] op, logic [WORD_W-1:0] data,
                                   logic lst);
    logic [CIDX_W-1:0] c;
    logic [CNT_W-1:0]  len;
    logic              hit;
    status_e           st;
    case (op)
      OP_PUSH: begin
        // first word of a packet: find a free cell or drop the packet
        if (!filling) begin
          filling    = 1'b1;
          discarding = 1'b1;
          fill_off   = '0;
          if (ring_occ < NUM_CELLS) begin
            c = prod_idx;
            for (int i = 0; i < NUM_CELLS; i++) begin
              if (discarding) begin
                if (cell_len[c] == '0) discarding = 1'b0;
                else c = ring_next(c);
              end
            end
            prod_idx  = c;
            fill_cell = c;
          end
          if (discarding && lost_pkts != '1) lost_pkts = lost_pkts + 1'b1;
        end
        if (discarding) begin
          if (lst) begin
            filling    = 1'b0;
            discarding = 1'b0;
          end
          owe(ST_DROPPED, '0, '0, '0, 1'b1);
        end else begin
          // store the word unless the cell is already full to the brim
          if (fill_off < CELL_WORDS) begin
            cell_mem[int'(fill_cell) * CELL_WORDS + int'(fill_off)] = data;
            fill_off = fill_off + 1'b1;
            st = ST_PUSHED;
          end else begin
            st = ST_TRUNC;
          end
          if (lst) begin
            cell_len[fill_cell] = fill_off;
            ring_occ = ring_occ + 1'b1;
            prod_idx = ring_next(fill_cell);
            filling  = 1'b0;
          end
          owe(st, '0, fill_cell, fill_off, 1'b1);
          if (lst) fill_off = '0;
        end
      end
      OP_PULL: begin
        // scan from the consumer for a filled cell
        c   = cons_idx;
        hit = 1'b0;
        if (ring_occ != '0) begin
          for (int i = 0; i < NUM_CELLS; i++) begin
            if (!hit) begin
              if (cell_len[c] != '0) hit = 1'b1;
              else c = ring_next(c);
            end
          end
        end
        if (!hit) begin
          owe(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          cons_idx = c;
          holding  = 1'b1;
          len      = cell_len[c];
          if (len > CELL_WORDS) len = CNT_W'(CELL_WORDS);
          for (int i = 0; i < len; i++) begin
            owe(ST_PULL_DATA, cell_mem[int'(c) * CELL_WORDS + i], c, len, i + 1 == len);
          end
        end
      end
      OP_RELEASE: begin
        if (!holding) begin
          owe(ST_REL_ERR, '0, '0, '0, 1'b1);
        end else begin
          c = cons_idx;
          cell_len[c] = '0;
          holding  = 1'b0;
          cons_idx = ring_next(c);
          if (ring_occ != '0) ring_occ = ring_occ - 1'b1;
          owe(ST_RELEASED, '0, c, '0, 1'b1);
        end
      end
      default: ;  // unused code: no result
    endcase
  endtask

  task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    $display("%0t ns: result %0d %s got %0h want %0h", $time, results_seen, field, got,
             want);
    mismatches++;
  endtask

  // compare one result word with the oldest owed one
  task automatic check_result();
    ring_result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch("unexpected, status", m_axis_tuser, '0);
    end else begin
      want = owed_results.pop_front();
      if (m_axis_tuser !== want.status)
        report_mismatch("status", m_axis_tuser, want.status);
      if (m_axis_tdata[WORD_W-1:0] !== want.word)
        report_mismatch("read_word", m_axis_tdata[WORD_W-1:0], want.word);
      if (m_axis_tdata[CELL_LSB +: CIDX_W] !== want.cell_idx)
        report_mismatch("cell_index", m_axis_tdata[CELL_LSB +: CIDX_W], want.cell_idx);
      if (m_axis_tdata[CNT_LSB +: CNT_W] !== want.count)
        report_mismatch("word_count", m_axis_tdata[CNT_LSB +: CNT_W], want.count);
      if (m_axis_tlast !== want.last)
        report_mismatch("last_of_run", m_axis_tlast, want.last);
      if (m_axis_tdata[LOST_LSB +: LOST_W] !== want.lost)
        report_mismatch("lost_count", m_axis_tdata[LOST_LSB +: LOST_W], want.lost);
      if (m_axis_tdata[OCC_LSB +: OCC_W] !== want.occ)
        report_mismatch("occupancy", m_axis_tdata[OCC_LSB +: OCC_W], want.occ);
      if (m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS_W] !== '0)
        report_mismatch("pad", m_axis_tdata[OUT_DATA_W-1:OUT_FIELDS_W], '0);
    end
    results_seen++;
  endtask

  // watch both channels; inputs first so a same-edge result finds its entry
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_idx   = '0;
      cons_idx   = '0;
      fill_cell  = '0;
      ring_occ   = '0;
      lost_pkts  = '0;
      filling    = 1'b0;
      discarding = 1'b0;
      holding    = 1'b0;
      fill_off   = '0;
      for (int i = 0; i < NUM_CELLS; i++) cell_len[i] = '0;
      owed_results.delete();
      mismatches   = 0;
      results_seen = 0;
      mismatch_count_o <= 0;
      owed_count_o     <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_ring_step(s_axis_tuser, s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        check_result();
      mismatch_count_o <= mismatches;
      owed_count_o     <= owed_results.size();
    end
  end

endmodule

[test/tb_packet_cell_ring_buffer.sv]
`timescale 1ns / 100ps
// testbench top for the packet cell ring buffer: stimulus, stalls and verdict
module tb_packet_cell_ring_buffer;
  import pcrb_pkg::*;

  localparam int NUM_CELLS    = 16;
  localparam int CELL_WORDS   = 8;
  localparam int RANDOM_WORDS = 420;
  localparam int CALM_FROM    = 360;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4 * NUM_CELLS + 2 * CELL_WORDS + 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [WORD_W-1:0]     s_axis_tdata  = '0;  // data_word
  logic [OP_W-1:0]       s_axis_tuser  = '0;  // opcode
  logic                  s_axis_tlast  = 1'b0;  // last_word
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // read_word, cell_index, word_count,
                                        // lost_count, occupancy, zero pad
  logic [STAT_W-1:0]     m_axis_tuser;  // status
  logic                  m_axis_tlast;  // last_of_run

  int mismatch_count;
  int owed_count;
  int cycle_count = 0;
  int words_sent  = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;
  bit steady      = 1'b0;

  packet_cell_ring_buffer #(
    .NUM_CELLS (NUM_CELLS),
    .CELL_WORDS(CELL_WORDS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  pcrb_checker #(
    .NUM_CELLS (NUM_CELLS),
    .CELL_WORDS(CELL_WORDS)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .mismatch_count_o(mismatch_count),
    .owed_count_o    (owed_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall bursts, no new burst starting while calm or steady
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // offer one word, maybe after a gap, and wait until it is taken
  task automatic send_word(logic [OP_W-1:0] op, logic [WORD_W-1:0] data, logic lst);
    int gap;
    gap = 0;
    if (!calm && !steady && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic push_packet(int len);
    for (int i = 1; i <= len; i++) send_word(OP_PUSH, {$urandom, $urandom}, i == len);
  endtask

  initial begin
    int choice;
    int push_bias;
    int phase_left;
    int random_start;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pull, stray release, extremes, oversize, repeat pull
    send_word(OP_PULL, '0, 1'b0);
    send_word(OP_RELEASE, '1, 1'b1);
    send_word(OP_PUSH, '0, 1'b1);
    for (int i = 1; i <= CELL_WORDS + 1; i++) send_word(OP_PUSH, '1, i == CELL_WORDS + 1);
    send_word(OP_PULL, '0, 1'b0);
    send_word(OP_PULL, '1, 1'b1);
    send_word(OP_RELEASE, '0, 1'b0);
    send_word(OP_UNUSED, {$urandom, $urandom}, 1'b1);
    send_word(OP_PUSH, {32{2'b01}}, 1'b0);
    send_word(OP_PUSH, {32{2'b10}}, 1'b1);
    send_word(OP_PULL, '0, 1'b0);
    send_word(OP_RELEASE, '0, 1'b0);
    send_word(OP_RELEASE, '0, 1'b0);

    // random: phases that fill the ring to overflow or drain it dry
    random_start = words_sent;
    phase_left   = 0;
    push_bias    = 55;
    while (words_sent - random_start < RANDOM_WORDS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       push_bias = 25;
          1:       push_bias = 55;
          default: push_bias = 85;
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (words_sent - random_start >= CALM_FROM) calm = 1'b1;
      choice = $urandom_range(0, 99);
      if (choice < 6) begin
        // noise: any code, any last flag, may break a packet in two
        send_word(OP_W'($urandom_range(0, 3)), {$urandom, $urandom},
                  1'($urandom_range(0, 1)));
      end else if (choice < push_bias) begin
        if ($urandom_range(0, 9) == 0)
          push_packet($urandom_range(CELL_WORDS + 1, CELL_WORDS + 3));
        else
          push_packet($urandom_range(1, CELL_WORDS));
      end else if (choice < push_bias + (100 - push_bias) / 5) begin
        if ($urandom_range(0, 1) == 0) send_word(OP_PULL, {$urandom, $urandom}, 1'b0);
        else send_word(OP_RELEASE, {$urandom, $urandom}, 1'b1);
      end else begin
        send_word(OP_PULL, {$urandom, $urandom}, 1'b1);
        send_word(OP_RELEASE, {$urandom, $urandom}, 1'b0);
      end
    end

    // drain: wait for every owed result, then a quiet tail
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pcrb_pkg.sv
src/pcrb_dp.sv
src/pcrb_ctrl.sv
src/packet_cell_ring_buffer.sv
test/pcrb_checker.sv
test/tb_packet_cell_ring_buffer.sv
